// ===== sv/tcp_pkg.sv =====
// ----------------------------------------------------------------------------
// tcp_pkg
// Shared types, codes and character tables for the text command parser.
// ----------------------------------------------------------------------------
package tcp_pkg;

  localparam int NUM_PREFIX = 10;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_MARKER = 3'd1;
  localparam logic [2:0] ST_EMPTY     = 3'd2;
  localparam logic [2:0] ST_RANGE     = 3'd3;
  localparam logic [2:0] ST_UNKNOWN   = 3'd4;

  // command types, same order as the prefix table
  localparam logic [3:0] CMD_AUTO    = 4'd0;
  localparam logic [3:0] CMD_MANUAL  = 4'd1;
  localparam logic [3:0] CMD_HEAT    = 4'd2;
  localparam logic [3:0] CMD_COOL    = 4'd3;
  localparam logic [3:0] CMD_DEHUMID = 4'd4;
  localparam logic [3:0] CMD_HUMID   = 4'd5;
  localparam logic [3:0] CMD_SET_THI = 4'd6;
  localparam logic [3:0] CMD_SET_TLO = 4'd7;
  localparam logic [3:0] CMD_SET_HHI = 4'd8;
  localparam logic [3:0] CMD_SET_HLO = 4'd9;

  // configuration register indexes
  localparam logic [1:0] REG_TEMP_MIN = 2'd0;
  localparam logic [1:0] REG_TEMP_MAX = 2'd1;
  localparam logic [1:0] REG_HUM_MIN  = 2'd2;
  localparam logic [1:0] REG_HUM_MAX  = 2'd3;

  localparam logic signed [15:0] TEMP_MIN_RST = -16'sd500;
  localparam logic signed [15:0] TEMP_MAX_RST = 16'sd1000;
  localparam logic signed [15:0] HUM_MIN_RST  = 16'sd0;
  localparam logic signed [15:0] HUM_MAX_RST  = 16'sd1000;

  // number scan phases
  localparam logic [1:0] NUM_SKIP = 2'd0;
  localparam logic [1:0] NUM_DIG  = 2'd1;
  localparam logic [1:0] NUM_DONE = 2'd2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_M     = 8'h6D;

  localparam logic [2:0] MARKER_LEN = 3'd4;

  // "msg=", first character in the top byte
  localparam logic [31:0] MARKER_TEXT = 32'h6D73_673D;

  // command prefixes, first character in the top byte
  localparam logic [31:0] PREFIX_TEXT [NUM_PREFIX] = '{
    32'h5A44_3A00,  // ZD:
    32'h5344_3A00,  // SD:
    32'h4B4A_523A,  // KJR:
    32'h4C5A_3A00,  // LZ:
    32'h4353_3A00,  // CS:
    32'h4A53_3A00,  // JS:
    32'h5448_3A00,  // TH:
    32'h544C_3A00,  // TL:
    32'h4848_3A00,  // HH:
    32'h484C_3A00   // HL:
  };

  localparam logic [2:0] PREFIX_LEN [NUM_PREFIX] = '{
    3'd3, 3'd3, 3'd4, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3
  };

  // what the evaluation stage needs from the scanner at buffer end
  typedef struct packed {
    logic        marker_done;
    logic [2:0]  ppos;
    logic        first_cr;
    logic        found;
    logic [3:0]  kind;
    logic        negative;
    logic [15:0] acc;
  } tcp_snap_t;

  function automatic logic [7:0] marker_char(input logic [1:0] idx);
    logic [4:0] sh;
    sh = 5'd24 - {idx, 3'b000};
    return MARKER_TEXT[sh +: 8];
  endfunction

  // lowest index of an alive prefix that is fully matched; {found, index}
  function automatic logic [4:0] completed_prefix(input logic [NUM_PREFIX-1:0] alive,
                                                  input logic [2:0] pos);
    logic [4:0] res;
    res = '0;
    for (int k = NUM_PREFIX - 1; k >= 0; k--) begin
      if (alive[k] && pos >= PREFIX_LEN[k]) begin
        res = {1'b1, 4'(k)};
      end
    end
    return res;
  endfunction

endpackage

// ===== sv/text_command_parser.sv =====
// ----------------------------------------------------------------------------
// text_command_parser
// Byte-serial parser for one text command buffer with range-checked value.
// ----------------------------------------------------------------------------
//  port group | direction | handshake            | payload
//  in_*       | input     | in_valid / in_stall  | in_rx_byte, in_last_byte
//  out_*      | output    | out_valid / out_stall| out_status, out_command_type,
//             |           |                      | out_command_value
//  cfg_*      | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  One byte is taken every cycle while in_stall is low. The result of a buffer
//  passes the input register, buffer-end snapshot and result register.
//  Synchronous active-low reset clears the scan state and loads the default
//  bounds. A stalled result holds only the last byte of a later buffer; other
//  bytes of the next buffer keep flowing, and one more finished buffer waits
//  in the snapshot stage before in_stall rises.
// ----------------------------------------------------------------------------
module text_command_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  input  logic               in_last_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic [3:0]         out_command_type,
  output logic signed [15:0] out_command_value,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  logic signed [15:0] temp_min_r, temp_max_r, hum_min_r, hum_max_r;
  logic               snap_valid, snap_ready;
  tcp_pkg::tcp_snap_t snap;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_min_r <= tcp_pkg::TEMP_MIN_RST;
      temp_max_r <= tcp_pkg::TEMP_MAX_RST;
      hum_min_r  <= tcp_pkg::HUM_MIN_RST;
      hum_max_r  <= tcp_pkg::HUM_MAX_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tcp_pkg::REG_TEMP_MIN: temp_min_r <= cfg_data;
        tcp_pkg::REG_TEMP_MAX: temp_max_r <= cfg_data;
        tcp_pkg::REG_HUM_MIN:  hum_min_r  <= cfg_data;
        tcp_pkg::REG_HUM_MAX:  hum_max_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  tcp_scan u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_rx_byte   (in_rx_byte),
    .in_last_byte (in_last_byte),
    .snap_ready   (snap_ready),
    .snap_valid   (snap_valid),
    .snap         (snap)
  );

  tcp_eval u_eval (
    .clk               (clk),
    .rst_n             (rst_n),
    .snap_valid        (snap_valid),
    .snap_ready        (snap_ready),
    .snap              (snap),
    .temp_min          (temp_min_r),
    .temp_max          (temp_max_r),
    .hum_min           (hum_min_r),
    .hum_max           (hum_max_r),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_command_type  (out_command_type),
    .out_command_value (out_command_value)
  );

endmodule

// ===== sv/tcp_scan.sv =====
// ----------------------------------------------------------------------------
// tcp_scan
// Input register and byte-wise scanner: marker, prefix match and number.
// ----------------------------------------------------------------------------
module tcp_scan (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_rx_byte,
  input  logic                in_last_byte,
  input  logic                snap_ready,
  output logic                snap_valid,
  output tcp_pkg::tcp_snap_t  snap
);

  logic        valid_r;
  logic [7:0]  byte_r;
  logic        last_r;
  logic        go;

  logic [2:0]  mprog_r, mprog_nxt;
  logic [2:0]  ppos_r, ppos_nxt;
  logic [tcp_pkg::NUM_PREFIX-1:0] alive_r, alive_nxt;
  logic [1:0]  nphase_r, nphase_nxt;
  logic        nneg_r, nneg_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic        fcr_r, fcr_nxt;
  logic        stop_r, stop_nxt;

  logic [7:0]  c;
  logic        is_digit, is_space, is_sign;
  logic [4:0]  done_old, done_new;
  logic [19:0] acc_mul;
  logic        accumulate;

  assign c        = byte_r;
  assign go       = valid_r && (!last_r || snap_ready);
  assign in_stall = valid_r && last_r && !snap_ready;

  assign is_digit = (c >= tcp_pkg::CH_ZERO) && (c <= tcp_pkg::CH_NINE);
  assign is_space = (c == tcp_pkg::CH_SPACE) || ((c >= tcp_pkg::CH_TAB) && (c <= tcp_pkg::CH_CR));
  assign is_sign  = (c == tcp_pkg::CH_PLUS) || (c == tcp_pkg::CH_MINUS);
  assign done_old = tcp_pkg::completed_prefix(alive_r, ppos_r);

  // acc * 10 + digit, saturating at 16 bits
  assign acc_mul = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + {16'd0, c[3:0]};

  always_comb begin
    mprog_nxt  = mprog_r;
    ppos_nxt   = ppos_r;
    alive_nxt  = alive_r;
    nphase_nxt = nphase_r;
    nneg_nxt   = nneg_r;
    acc_nxt    = acc_r;
    fcr_nxt    = fcr_r;
    stop_nxt   = stop_r;
    accumulate = 1'b0;

    if (mprog_r >= tcp_pkg::MARKER_LEN) begin
      if (!stop_r) begin
        if (c == tcp_pkg::CH_NUL) begin
          stop_nxt = 1'b1;
          if (!done_old[4]) begin
            alive_nxt = '0;
          end else if (nphase_r != tcp_pkg::NUM_DONE) begin
            nphase_nxt = tcp_pkg::NUM_DONE;
          end
        end else if (done_old[4]) begin
          case (nphase_r)
            tcp_pkg::NUM_SKIP: begin
              if (is_sign) begin
                nneg_nxt   = (c == tcp_pkg::CH_MINUS);
                nphase_nxt = tcp_pkg::NUM_DIG;
              end else if (is_digit) begin
                nphase_nxt = tcp_pkg::NUM_DIG;
                accumulate = 1'b1;
              end else if (!is_space) begin
                nphase_nxt = tcp_pkg::NUM_DONE;
              end
            end
            tcp_pkg::NUM_DIG: begin
              if (is_digit) begin
                accumulate = 1'b1;
              end else begin
                nphase_nxt = tcp_pkg::NUM_DONE;
              end
            end
            default: begin
            end
          endcase
        end else begin
          for (int k = 0; k < tcp_pkg::NUM_PREFIX; k++) begin
            if (ppos_r >= tcp_pkg::PREFIX_LEN[k] ||
                tcp_pkg::PREFIX_TEXT[k][5'd24 - {ppos_r[1:0], 3'b000} +: 8] != c) begin
              alive_nxt[k] = 1'b0;
            end
          end
        end
      end
      if (ppos_r == 3'd0) begin
        fcr_nxt = !stop_nxt && (c == tcp_pkg::CH_CR);
      end else if (ppos_r == 3'd1 && !(fcr_r && c == tcp_pkg::CH_LF && !stop_nxt)) begin
        fcr_nxt = 1'b0;
      end
      if (ppos_r != 3'd7) begin
        ppos_nxt = ppos_r + 3'd1;
      end
    end else if (!stop_r) begin
      if (c == tcp_pkg::CH_NUL) begin
        stop_nxt = 1'b1;
      end else if (c == tcp_pkg::marker_char(mprog_r[1:0])) begin
        mprog_nxt = mprog_r + 3'd1;
      end else begin
        mprog_nxt = (c == tcp_pkg::CH_M) ? 3'd1 : 3'd0;
      end
    end

    if (accumulate) begin
      acc_nxt = (acc_mul[19:16] != 4'd0) ? 16'hFFFF : acc_mul[15:0];
    end
  end

  assign done_new = tcp_pkg::completed_prefix(alive_nxt, ppos_nxt);

  assign snap_valid       = valid_r && last_r;
  assign snap.marker_done = (mprog_nxt >= tcp_pkg::MARKER_LEN);
  assign snap.ppos        = ppos_nxt;
  assign snap.first_cr    = fcr_nxt;
  assign snap.found       = done_new[4];
  assign snap.kind        = done_new[3:0];
  assign snap.negative    = nneg_nxt;
  assign snap.acc         = acc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      byte_r <= in_rx_byte;
      last_r <= in_last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mprog_r  <= '0;
      ppos_r   <= '0;
      alive_r  <= '1;
      nphase_r <= tcp_pkg::NUM_SKIP;
      nneg_r   <= 1'b0;
      acc_r    <= '0;
      fcr_r    <= 1'b0;
      stop_r   <= 1'b0;
    end else if (go) begin
      if (last_r) begin
        // buffer done: back to the idle scan state
        mprog_r  <= '0;
        ppos_r   <= '0;
        alive_r  <= '1;
        nphase_r <= tcp_pkg::NUM_SKIP;
        nneg_r   <= 1'b0;
        acc_r    <= '0;
        fcr_r    <= 1'b0;
        stop_r   <= 1'b0;
      end else begin
        mprog_r  <= mprog_nxt;
        ppos_r   <= ppos_nxt;
        alive_r  <= alive_nxt;
        nphase_r <= nphase_nxt;
        nneg_r   <= nneg_nxt;
        acc_r    <= acc_nxt;
        fcr_r    <= fcr_nxt;
        stop_r   <= stop_nxt;
      end
    end
  end

endmodule

// ===== sv/tcp_eval.sv =====
// ----------------------------------------------------------------------------
// tcp_eval
// Buffer-end snapshot register, status/range check and result register.
// ----------------------------------------------------------------------------
module tcp_eval (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                snap_valid,
  output logic                snap_ready,
  input  tcp_pkg::tcp_snap_t  snap,
  input  logic signed [15:0]  temp_min,
  input  logic signed [15:0]  temp_max,
  input  logic signed [15:0]  hum_min,
  input  logic signed [15:0]  hum_max,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          out_status,
  output logic [3:0]          out_command_type,
  output logic signed [15:0]  out_command_value
);

  logic               sv_r;
  tcp_pkg::tcp_snap_t snap_r;
  logic               ov_r;
  logic [2:0]         status_r, status_nxt;
  logic [3:0]         type_r, type_nxt;
  logic signed [15:0] value_r, value_nxt;
  logic               out_ready;
  logic signed [16:0] v, lo, hi;

  assign out_ready  = !ov_r || !out_stall;
  assign snap_ready = !sv_r || out_ready;

  assign v = snap_r.negative ? -$signed({1'b0, snap_r.acc}) : $signed({1'b0, snap_r.acc});

  always_comb begin
    if (snap_r.kind <= tcp_pkg::CMD_HUMID) begin
      lo = 17'sd0;
      hi = 17'sd1;
    end else if (snap_r.kind <= tcp_pkg::CMD_SET_TLO) begin
      lo = 17'(temp_min);
      hi = 17'(temp_max);
    end else begin
      lo = 17'(hum_min);
      hi = 17'(hum_max);
    end
  end

  always_comb begin
    type_nxt  = tcp_pkg::CMD_AUTO;
    value_nxt = '0;
    if (!snap_r.marker_done) begin
      status_nxt = tcp_pkg::ST_NO_MARKER;
    end else if (snap_r.ppos == 3'd0 || (snap_r.first_cr && snap_r.ppos >= 3'd2)) begin
      status_nxt = tcp_pkg::ST_EMPTY;
    end else if (!snap_r.found) begin
      status_nxt = tcp_pkg::ST_UNKNOWN;
    end else begin
      type_nxt = snap_r.kind;
      if (v < lo || v > hi) begin
        status_nxt = tcp_pkg::ST_RANGE;
      end else begin
        status_nxt = tcp_pkg::ST_OK;
        value_nxt  = v[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (snap_ready) begin
        sv_r <= snap_valid;
      end
      if (out_ready) begin
        ov_r <= sv_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (snap_ready && snap_valid) begin
      snap_r <= snap;
    end
    if (out_ready && sv_r) begin
      status_r <= status_nxt;
      type_r   <= type_nxt;
      value_r  <= value_nxt;
    end
  end

  assign out_valid         = ov_r;
  assign out_status        = status_r;
  assign out_command_type  = type_r;
  assign out_command_value = value_r;

endmodule

// ===== sv/tcp_checker.sv =====
// ----------------------------------------------------------------------------
// tcp_checker
// Port-level checks on the result channel of the text command parser.
// ----------------------------------------------------------------------------
module tcp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic [2:0]         out_status,
  input logic [3:0]         out_command_type,
  input logic signed [15:0] out_command_value
);

  // a stalled transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_command_type) && $stable(out_command_value))
    else $error("result changed while stalled");

  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != tcp_pkg::ST_OK |-> out_command_value == 16'sd0)
    else $error("value nonzero on a failed parse");

  a_type_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == tcp_pkg::ST_NO_MARKER || out_status == tcp_pkg::ST_EMPTY ||
      out_status == tcp_pkg::ST_UNKNOWN) |-> out_command_type == tcp_pkg::CMD_AUTO)
    else $error("command type set without a matched prefix");

  // switch commands only ever carry 0 or 1
  a_switch_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == tcp_pkg::ST_OK && out_command_type <= tcp_pkg::CMD_HUMID
      |-> out_command_value == 16'sd0 || out_command_value == 16'sd1)
    else $error("switch command value outside 0..1");

endmodule

bind text_command_parser tcp_checker u_tcp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_status        (out_status),
  .out_command_type  (out_command_type),
  .out_command_value (out_command_value)
);

// ===== bench/text_command_parser_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_command_parser_check
// Watches the byte, result and register channels of the parser. It predicts
// status, command type and value for every finished buffer. It compares
// each result transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module text_command_parser_check (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  input  logic               in_last_byte,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [2:0]         out_status,
  input  logic [3:0]         out_command_type,
  input  logic signed [15:0] out_command_value,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 mismatches,
  output int                 pending
);
  import tcp_pkg::*;

  typedef struct {
    logic [2:0]         status;
    logic [3:0]         kind;
    logic signed [15:0] value;
  } cmd_result_t;

  cmd_result_t predicted_cmds[$];
  int err_cnt = 0;

  // bounds as last written
  logic signed [15:0] t_lo, t_hi, h_lo, h_hi;

  // scan state of the buffer in flight
  logic [2:0]  mk_cnt;
  logic [2:0]  pl_pos;
  logic [9:0]  alive;
  logic [1:0]  num_phase;
  logic        num_neg;
  logic [15:0] num_acc;
  logic        lead_cr;
  logic        halted;

  task automatic report_mismatch(input string what);
    err_cnt++;
    $display("%0t ns: parser mismatch: %s", $time, what);
  endtask

  task automatic clear_scan();
    mk_cnt = '0;
    pl_pos = '0;
    alive = '1;
    num_phase = NUM_SKIP;
    num_neg = 1'b0;
    num_acc = '0;
    lead_cr = 1'b0;
    halted = 1'b0;
  endtask

  function automatic logic [7:0] prefix_char(input int k, input int pos);
    logic [31:0] w;
    w = PREFIX_TEXT[k];
    return 8'(w >> (24 - 8 * (pos % 4)));
  endfunction

  // lowest alive prefix whose text is complete, or -1
  function automatic int matched_cmd();
    for (int k = 0; k < NUM_PREFIX; k++) begin
      if (alive[k] && pl_pos >= PREFIX_LEN[k]) begin
        return k;
      end
    end
    return -1;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  task automatic take_number(input logic [7:0] c);
    logic digit;
    int acc;
    digit = c >= CH_ZERO && c <= CH_NINE;
    if (num_phase == NUM_SKIP) begin
      if (is_blank(c)) return;
      if (c == CH_PLUS || c == CH_MINUS) begin
        num_neg = (c == CH_MINUS);
        num_phase = NUM_DIG;
        return;
      end
      if (!digit) begin
        num_phase = NUM_DONE;
        return;
      end
      num_phase = NUM_DIG;
    end else if (num_phase != NUM_DIG) begin
      return;
    end else if (!digit) begin
      num_phase = NUM_DONE;
      return;
    end
    acc = int'(num_acc) * 10 + int'(c) - int'(CH_ZERO);
    num_acc = (acc > 65535) ? 16'hFFFF : 16'(acc);
  endtask

  task automatic take_payload(input logic [7:0] c);
    logic [2:0] pos;
    int done;
    pos = pl_pos;
    if (!halted) begin
      done = matched_cmd();
      if (c == CH_NUL) begin
        halted = 1'b1;
        if (done < 0) alive = '0;
        else if (num_phase < NUM_DONE) num_phase = NUM_DONE;
      end else if (done >= 0) begin
        take_number(c);
      end else begin
        for (int k = 0; k < NUM_PREFIX; k++) begin
          if (pos >= PREFIX_LEN[k] || prefix_char(k, pos) != c) alive[k] = 1'b0;
        end
      end
    end
    // CR LF at the very start of the payload marks it empty
    if (pos == 0) begin
      lead_cr = !halted && c == CH_CR;
    end else if (pos == 1 && !(lead_cr && c == CH_LF && !halted)) begin
      lead_cr = 1'b0;
    end
    if (pl_pos < 7) pl_pos++;
  endtask

  task automatic parse_byte(input logic [7:0] c, input logic last);
    cmd_result_t r;
    int k, v, lo, hi;
    if (mk_cnt >= MARKER_LEN) begin
      take_payload(c);
    end else if (!halted) begin
      if (c == CH_NUL) halted = 1'b1;
      else if (c == 8'(MARKER_TEXT >> (24 - 8 * int'(mk_cnt)))) mk_cnt++;
      else mk_cnt = (c == CH_M) ? 3'd1 : 3'd0;
    end
    if (!last) return;

    r.kind = CMD_AUTO;
    r.value = '0;
    if (mk_cnt < MARKER_LEN) begin
      r.status = ST_NO_MARKER;
    end else if (pl_pos == 0 || (lead_cr && pl_pos >= 2)) begin
      r.status = ST_EMPTY;
    end else begin
      k = matched_cmd();
      if (k < 0) begin
        r.status = ST_UNKNOWN;
      end else begin
        v = num_neg ? -int'(num_acc) : int'(num_acc);
        if (k <= int'(CMD_HUMID)) begin
          lo = 0;
          hi = 1;
        end else if (k <= int'(CMD_SET_TLO)) begin
          lo = int'(t_lo);
          hi = int'(t_hi);
        end else begin
          lo = int'(h_lo);
          hi = int'(h_hi);
        end
        r.kind = 4'(k);
        if (v < lo || v > hi) begin
          r.status = ST_RANGE;
        end else begin
          r.status = ST_OK;
          r.value = 16'(v);
        end
      end
    end
    predicted_cmds.push_back(r);
    clear_scan();
  endtask

  task automatic check_output();
    cmd_result_t want;
    if (predicted_cmds.size() == 0) begin
      report_mismatch($sformatf("result with no buffer pending (status %0d)", out_status));
      return;
    end
    want = predicted_cmds.pop_front();
    if (out_status !== want.status) begin
      report_mismatch($sformatf("status %0d, predicted %0d", out_status, want.status));
    end
    if (out_command_type !== want.kind) begin
      report_mismatch($sformatf("command type %0d, predicted %0d",
                                out_command_type, want.kind));
    end
    if (out_command_value !== want.value) begin
      report_mismatch($sformatf("command value %0d, predicted %0d",
                                out_command_value, want.value));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_scan();
      t_lo = TEMP_MIN_RST;
      t_hi = TEMP_MAX_RST;
      h_lo = HUM_MIN_RST;
      h_hi = HUM_MAX_RST;
      predicted_cmds.delete();
    end else begin
      // results leave before the byte of this edge is taken
      if (out_valid && !out_stall) check_output();
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TEMP_MIN: t_lo = cfg_data;
          REG_TEMP_MAX: t_hi = cfg_data;
          REG_HUM_MIN:  h_lo = cfg_data;
          REG_HUM_MAX:  h_hi = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) parse_byte(in_rx_byte, in_last_byte);
    end
    mismatches <= err_cnt;
    pending <= predicted_cmds.size();
  end

endmodule

// ===== bench/text_command_parser_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_command_parser_test
// Sends directed and random text buffers through the parser under several
// bound settings and idle patterns. The checker beside the block judges
// every result.
// ----------------------------------------------------------------------------
module text_command_parser_test;
  import tcp_pkg::*;

  localparam int IDLE_LIMIT = 4000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_rx_byte = '0;
  logic               in_last_byte = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [2:0]         out_status;
  logic [3:0]         out_command_type;
  logic signed [15:0] out_command_value;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;
  int                 mismatches;
  int                 pending;

  int send_idle = 0;
  int recv_idle = 0;

  // bounds currently loaded, used to aim values at the edges
  int tlo = int'(TEMP_MIN_RST);
  int thi = int'(TEMP_MAX_RST);
  int hlo = int'(HUM_MIN_RST);
  int hhi = int'(HUM_MAX_RST);

  logic [7:0] frame[$];
  string cmd_text [NUM_PREFIX] = '{"ZD:", "SD:", "KJR:", "LZ:", "CS:",
                                   "JS:", "TH:", "TL:", "HH:", "HL:"};

  text_command_parser dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_rx_byte(in_rx_byte), .in_last_byte(in_last_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_command_type(out_command_type),
    .out_command_value(out_command_value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  text_command_parser_check u_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_rx_byte(in_rx_byte), .in_last_byte(in_last_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_command_type(out_command_type),
    .out_command_value(out_command_value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .pending(pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle);
  end

  // ends the run when no transaction of any kind moves for too long
  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
    end
    $display("[text_command_parser] ERROR");
    $finish;
  end

  function automatic int rand16();
    return int'($urandom_range(65535)) - 32768;
  endfunction

  task automatic add_byte(input logic [7:0] b);
    frame.push_back(b);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) frame.push_back(s[i]);
  endtask

  task automatic add_blank();
    add_byte(($urandom_range(5) == 0) ? CH_SPACE : 8'($urandom_range(13, 9)));
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    in_last_byte <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame.size(); i++) send_byte(frame[i], i == frame.size() - 1);
    frame.delete();
  endtask

  task automatic directed(input string s);
    add_text(s);
    send_frame();
  endtask

  // lets every pending result out, then gives the pipeline time to empty
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_bounds(input int a, input int b, input int c, input int d);
    write_reg(REG_TEMP_MIN, 16'(a));
    write_reg(REG_TEMP_MAX, 16'(b));
    write_reg(REG_HUM_MIN, 16'(c));
    write_reg(REG_HUM_MAX, 16'(d));
    cfg_valid <= 1'b0;
    @(posedge clk);
    tlo = a;
    thi = b;
    hlo = c;
    hhi = d;
  endtask

  task automatic pick_value(input int k, output int v);
    int lo, hi;
    if (k <= int'(CMD_HUMID)) begin
      lo = 0;
      hi = 1;
    end else if (k <= int'(CMD_SET_TLO)) begin
      lo = tlo;
      hi = thi;
    end else begin
      lo = hlo;
      hi = hhi;
    end
    case ($urandom_range(9))
      0: v = lo;
      1: v = hi;
      2: v = lo - 1;
      3: v = hi + 1;
      4, 5: v = (lo <= hi) ? lo + int'($urandom_range(hi - lo)) : lo;
      6: v = int'($urandom_range(140000)) - 70000;
      7: v = 0;
      8: v = rand16();
      default: v = lo + int'($urandom_range(3));
    endcase
  endtask

  task automatic build_command_frame();
    int k, v, mag, sel, idx;
    k = $urandom_range(NUM_PREFIX - 1);
    if ($urandom_range(99) < 25) begin
      case ($urandom_range(3))
        0: add_text("m");
        1: add_text("ms");
        2: add_text("msg");
        default: add_byte(8'($urandom_range(255, 1)));
      endcase
    end
    add_text("msg=");
    add_text(cmd_text[k]);
    if ($urandom_range(99) < 10) begin
      idx = frame.size() - cmd_text[k].len() + int'($urandom_range(cmd_text[k].len() - 1));
      frame[idx] = 8'($urandom_range(255));
    end
    pick_value(k, v);
    if ($urandom_range(99) < 20) repeat ($urandom_range(2, 1)) add_blank();
    sel = $urandom_range(99);
    if (sel < 5) begin
      // sign without digits, or nothing at all
      if ($urandom_range(1)) add_byte((v < 0) ? CH_MINUS : CH_PLUS);
    end else begin
      if (v < 0) add_byte(CH_MINUS);
      else if ($urandom_range(3) == 0) add_byte(CH_PLUS);
      mag = (v < 0) ? -v : v;
      if (sel < 13) add_byte(CH_ZERO);
      if (sel >= 92) begin
        add_byte(8'(int'(CH_ZERO) + int'($urandom_range(9, 1))));
        repeat ($urandom_range(9, 5)) add_byte(8'(int'(CH_ZERO) + int'($urandom_range(9))));
      end else begin
        add_text($sformatf("%0d", mag));
      end
    end
    case ($urandom_range(9))
      0: begin
        add_byte(CH_CR);
        add_byte(CH_LF);
      end
      1: add_byte(8'($urandom_range(255)));
      2: begin
        add_byte(CH_NUL);
        add_byte(8'($urandom_range(255)));
      end
      default: ;
    endcase
  endtask

  task automatic build_random_frame();
    int sel;
    sel = $urandom_range(99);
    if (sel < 72) begin
      build_command_frame();
    end else if (sel < 80) begin
      add_text("msg=");
      repeat ($urandom_range(6, 1)) add_byte(8'($urandom_range(255)));
    end else if (sel < 88) begin
      repeat ($urandom_range(8, 1)) add_byte(8'($urandom_range(255)));
    end else if (sel < 94) begin
      add_text("msg=");
      case ($urandom_range(2))
        0: ;
        1: begin
          add_byte(CH_CR);
          add_byte(CH_LF);
          add_text(cmd_text[$urandom_range(NUM_PREFIX - 1)]);
          add_byte(8'(int'(CH_ZERO) + int'($urandom_range(9))));
        end
        default: add_byte(CH_CR);
      endcase
    end else begin
      // zero byte dropped somewhere into a command
      add_text("msg=");
      add_text(cmd_text[$urandom_range(NUM_PREFIX - 1)]);
      add_byte(8'(int'(CH_ZERO) + int'($urandom_range(9))));
      frame[$urandom_range(frame.size() - 1)] = CH_NUL;
    end
  endtask

  task automatic directed_tests();
    directed("msg=ZD:1");
    directed("msg=SD:0");
    directed("msg=KJR:1");
    directed("msg=LZ:-0");
    directed("msg=CS: +1");
    directed("msg=JS:2");
    directed("msg=TH:-500");
    directed("msg=TL:1001");
    directed("msg=HH:1000");
    directed("msg=HL:-1");
    directed("hello");
    directed("msg=");
    add_text("msg=");
    add_byte(CH_CR);
    add_byte(CH_LF);
    directed("TH:5");
    add_text("msg=");
    add_byte(CH_CR);
    send_frame();
    add_text("msg=");
    add_byte(CH_NUL);
    send_frame();
    directed("msg=TH:99999999");
    directed("msg=TH:abc");
    directed("mmsg=XY:1");
    add_text("ms");
    add_byte(CH_NUL);
    directed("msg=ZD:1");
    add_text("msg=TH:12");
    add_byte(CH_NUL);
    directed("5");
    add_text("msg=ZD:\t\n\v\f");
    add_byte(CH_CR);
    directed(" 1");
    add_text("msg=HH:");
    add_byte(CH_CR);
    add_byte(CH_LF);
    directed("50");
    add_text("msg=");
    add_byte(8'hFF);
    send_frame();
    add_byte(CH_NUL);
    send_frame();
  endtask

  initial begin
    int v;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle = 6;
    recv_idle = 62;
    directed_tests();
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: load_bounds(-32768, 32767, -32768, 32767);
        1: load_bounds(100, -100, 32767, -32768);
        2: load_bounds(rand16(), rand16(), rand16(), rand16());
        3: begin
          v = int'($urandom_range(200)) - 100;
          load_bounds(v, v, 0, 0);
        end
        4: load_bounds(rand16(), rand16(), rand16(), rand16());
        default: load_bounds(int'(TEMP_MIN_RST), int'(TEMP_MAX_RST),
                             int'(HUM_MIN_RST), int'(HUM_MAX_RST));
      endcase
      if (ph == 2) begin
        send_idle = 62;
        recv_idle = 6;
      end else if (ph == 4) begin
        send_idle = 0;
        recv_idle = 0;
      end
      repeat (13) begin
        build_random_frame();
        send_frame();
      end
    end
    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("[text_command_parser] OK");
    else
      $display("[text_command_parser] ERROR");
    $finish;
  end

endmodule
